[design/rgb565_nearest_palette_index_top_assert.svh]
// Assertion macros for the nearest palette index block.
`ifndef RGB565_NEAREST_PALETTE_INDEX_TOP_ASSERT_SVH
`define RGB565_NEAREST_PALETTE_INDEX_TOP_ASSERT_SVH

`ifndef SYNTHESIS
// Check a property on every rising clock edge outside reset.
`define RNPI_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);
// Check a property on every rising clock edge, reset included.
`define RNPI_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) (prop)) else $error(msg);
`else
`define RNPI_ASSERT(lbl, prop, msg)
`define RNPI_ASSERT_ALWAYS(lbl, prop, msg)
`endif

`endif

[design/rnpi_pkg.sv]
// Shared types, constants and palette reset table for the nearest palette index block.
package rnpi_pkg;

  localparam int ENTRIES_DEF = 256;
  localparam int IDX_W       = 8;
  localparam int COLOR_W     = 16;
  localparam int DIST_W      = 13;

  // Starting bound of the search; every real distance is below it
  localparam logic [DIST_W-1:0] DIST_BOUND = DIST_W'(32 * 32 + 64 * 64 + 32 * 32);

  // Item kinds carried in tuser
  localparam logic MODE_QUERY = 1'b0;
  localparam logic MODE_WRITE = 1'b1;

  // One item moving down the compare chain
  typedef struct packed {
    logic               valid;
    logic               wr;
    logic [COLOR_W-1:0] color;
    logic [IDX_W-1:0]   idx;
    logic [DIST_W-1:0]  best_dist;
    logic [IDX_W-1:0]   best_idx;
  } stage_t;

  // Palette contents after reset
  function automatic logic [COLOR_W-1:0] palette_init(input logic [IDX_W-1:0] k);
    logic [IDX_W-1:0]   g;
    logic [COLOR_W-1:0] v;
    g = k - IDX_W'(32);
    unique case (k[7:5])
      3'd0:       v = {11'd0, k[4:0]};
      3'd1, 3'd2: v = {5'd0, g[5:0], 5'd0};
      3'd3:       v = {k[4:0], 11'd0};
      3'd4:       v = {5'd0, 6'd16, k[4:0]};
      3'd5:       v = {k[4:0], 6'd16, 5'd0};
      3'd6:       v = {5'd0, 6'd48, k[4:0]};
      3'd7:       v = {k[4:0], 6'd48, 5'd0};
    endcase
    if (k == '0) begin
      v = 16'hFFFF;
    end
    return v;
  endfunction

endpackage

[design/rgb565_nearest_palette_index_top.sv]
// Top level of the RGB565 nearest palette index search.
// Each query pixel walks a chain of ENTRIES compare cells, one palette entry per
// cell, and leaves with the lowest index at minimum squared RGB565 distance. The
// block takes one item per clock while the output is not stalled; a query result
// is presented once it has crossed the ENTRIES cell registers; the last cell's
// register is the output register. A write item (tuser high) travels the same chain
// and updates its entry as it passes, so it affects exactly the queries behind it; it
// gives no result, and a write beyond the palette changes nothing. A stall on the
// output holds the whole chain. The palette comes out of reset already loaded.
`include "rgb565_nearest_palette_index_top_assert.svh"

module rgb565_nearest_palette_index_top #(
  parameter int ENTRIES = rnpi_pkg::ENTRIES_DEF
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [23:0] s_axis_tdata,   // [15:0] pixel_color, [23:16] entry_index
  input  logic        s_axis_tuser,   // [0] mode
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [7:0]  m_axis_tdata    // [7:0] nearest_index
);

  rnpi_pkg::stage_t chain [ENTRIES+1];
  rnpi_pkg::stage_t last;
  logic             en;

  // Hold the chain while a result waits
  assign last          = chain[ENTRIES];
  assign m_axis_tvalid = last.valid && !last.wr;
  assign m_axis_tdata  = last.best_idx;
  assign en            = !m_axis_tvalid || m_axis_tready;
  assign s_axis_tready = en;

  // Load a fresh item into the head of the chain
  always_comb begin
    chain[0].valid     = s_axis_tvalid;
    chain[0].wr        = (s_axis_tuser == rnpi_pkg::MODE_WRITE);
    chain[0].color     = s_axis_tdata[15:0];
    chain[0].idx       = s_axis_tdata[23:16];
    chain[0].best_dist = rnpi_pkg::DIST_BOUND;
    chain[0].best_idx  = '0;
  end

  for (genvar k = 0; k < ENTRIES; k++) begin : g_cell
    rnpi_cell #(
      .IDX(k)
    ) u_cell (
      .clk_i  (clk_i),
      .rst_ni (rst_ni),
      .en_i   (en),
      .stage_i(chain[k]),
      .stage_o(chain[k+1])
    );
  end

  `RNPI_ASSERT(a_no_take_on_stall, (m_axis_tvalid && !m_axis_tready) |-> !s_axis_tready, "input taken while output stalled")
  `RNPI_ASSERT(a_idx_in_range, m_axis_tvalid |-> (32'(m_axis_tdata) < ENTRIES), "result index beyond palette")
  `RNPI_ASSERT_ALWAYS(a_found_match, m_axis_tvalid |-> (last.best_dist < rnpi_pkg::DIST_BOUND), "query left chain without a match")

endmodule

[design/rnpi_cell.sv]
// One compare cell: holds a palette entry and updates the running best match.
module rnpi_cell #(
  parameter int IDX = 0
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            en_i,
  input  rnpi_pkg::stage_t stage_i,
  output rnpi_pkg::stage_t stage_o
);

  localparam logic [rnpi_pkg::IDX_W-1:0] IDX_CODE = rnpi_pkg::IDX_W'(IDX);

  logic [rnpi_pkg::COLOR_W-1:0] entry_q;
  logic [rnpi_pkg::COLOR_W-1:0] entry_d;
  logic                         valid_q;
  rnpi_pkg::stage_t             stage_q;
  rnpi_pkg::stage_t             stage_d;

  logic [5:0]                   dr, dg, db;
  logic [11:0]                  sr, sg, sb;
  logic [rnpi_pkg::DIST_W-1:0]  cand_dist;

  // Absolute field differences
  always_comb begin
    dr = (stage_i.color[15:11] >= entry_q[15:11])
         ? 6'(stage_i.color[15:11] - entry_q[15:11])
         : 6'(entry_q[15:11] - stage_i.color[15:11]);
    dg = (stage_i.color[10:5] >= entry_q[10:5])
         ? (stage_i.color[10:5] - entry_q[10:5])
         : (entry_q[10:5] - stage_i.color[10:5]);
    db = (stage_i.color[4:0] >= entry_q[4:0])
         ? 6'(stage_i.color[4:0] - entry_q[4:0])
         : 6'(entry_q[4:0] - stage_i.color[4:0]);
    sr = {6'd0, dr} * {6'd0, dr};
    sg = {6'd0, dg} * {6'd0, dg};
    sb = {6'd0, db} * {6'd0, db};
    cand_dist = rnpi_pkg::DIST_W'(sr) + rnpi_pkg::DIST_W'(sg) + rnpi_pkg::DIST_W'(sb);
  end

  // Take this entry only when strictly closer, so lower indexes win ties
  always_comb begin
    stage_d = stage_i;
    if (!stage_i.wr && (cand_dist < stage_i.best_dist)) begin
      stage_d.best_dist = cand_dist;
      stage_d.best_idx  = IDX_CODE;
    end
  end

  // Overwrite the entry when a write for this index passes
  always_comb begin
    entry_d = entry_q;
    if (en_i && stage_i.valid && stage_i.wr && (stage_i.idx == IDX_CODE)) begin
      entry_d = stage_i.color;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      entry_q <= rnpi_pkg::palette_init(IDX_CODE);
      valid_q <= 1'b0;
    end else begin
      entry_q <= entry_d;
      if (en_i) begin
        valid_q <= stage_i.valid;
      end
    end
  end

  // Advance the payload with the chain
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      stage_q <= stage_d;
    end
  end

  always_comb begin
    stage_o       = stage_q;
    stage_o.valid = valid_q;
  end

endmodule

[sim/tb_rgb565_nearest_palette_index_top.sv]
// Self-checking testbench for the RGB565 nearest palette index block.
`timescale 1ns / 1ps

module tb_rgb565_nearest_palette_index_top;

  localparam int ENTRIES     = rnpi_pkg::ENTRIES_DEF;
  localparam int RAND_ITEMS  = 1126;
  localparam int CALM_ITEMS  = 150;
  localparam int DRAIN_AT    = 700;
  localparam int HOLD_AFTER  = 60;
  localparam int LONG_HOLD   = 450;
  localparam int QUIET_LIMIT = 4000;
  localparam int DIR_N       = 24;

  // One directed row: item fields, plus a known answer where it is obvious
  typedef struct packed {
    logic        mode;
    logic [15:0] color;
    logic [7:0]  idx;
    logic        known;
    logic [7:0]  known_idx;
  } pal_row_t;

  localparam pal_row_t DIR_ROWS [DIR_N] = '{
    '{rnpi_pkg::MODE_QUERY, 16'hFFFF, 8'h00, 1'b1, 8'd0},    // white hits entry 0
    '{rnpi_pkg::MODE_QUERY, 16'h0000, 8'hFF, 1'b1, 8'd32},   // black ties green and red ramps
    '{rnpi_pkg::MODE_QUERY, 16'h001F, 8'h00, 1'b1, 8'd31},
    '{rnpi_pkg::MODE_QUERY, 16'hF800, 8'h00, 1'b1, 8'd127},
    '{rnpi_pkg::MODE_QUERY, 16'h07E0, 8'h00, 1'b1, 8'd95},
    '{rnpi_pkg::MODE_QUERY, 16'h0001, 8'hAB, 1'b1, 8'd1},
    '{rnpi_pkg::MODE_QUERY, 16'h0200, 8'h00, 1'b1, 8'd48},   // green 16 ties its mixed ramp
    '{rnpi_pkg::MODE_QUERY, 16'h0600, 8'h00, 1'b1, 8'd80},   // green 48 ties its mixed ramp
    '{rnpi_pkg::MODE_QUERY, 16'hF81F, 8'h00, 1'b0, 8'd0},
    '{rnpi_pkg::MODE_QUERY, 16'hFFE0, 8'h00, 1'b0, 8'd0},
    '{rnpi_pkg::MODE_QUERY, 16'h07FF, 8'h00, 1'b0, 8'd0},
    '{rnpi_pkg::MODE_QUERY, 16'hAAAA, 8'h55, 1'b0, 8'd0},
    '{rnpi_pkg::MODE_QUERY, 16'h5555, 8'hAA, 1'b0, 8'd0},
    '{rnpi_pkg::MODE_WRITE, 16'h0000, 8'h00, 1'b0, 8'd0},
    '{rnpi_pkg::MODE_QUERY, 16'h0000, 8'h00, 1'b1, 8'd0},    // black now lowest at entry 0
    '{rnpi_pkg::MODE_WRITE, 16'h1234, 8'hFF, 1'b0, 8'd0},
    '{rnpi_pkg::MODE_QUERY, 16'h1234, 8'h00, 1'b1, 8'd255},
    '{rnpi_pkg::MODE_WRITE, 16'h0001, 8'd200, 1'b0, 8'd0},
    '{rnpi_pkg::MODE_QUERY, 16'h0001, 8'h00, 1'b1, 8'd1},    // exact tie, lower index wins
    '{rnpi_pkg::MODE_WRITE, 16'hFFFF, 8'h00, 1'b0, 8'd0},
    '{rnpi_pkg::MODE_WRITE, 16'hFFFF, 8'h01, 1'b0, 8'd0},
    '{rnpi_pkg::MODE_QUERY, 16'hFFFF, 8'h00, 1'b1, 8'd0},
    '{rnpi_pkg::MODE_QUERY, 16'h0001, 8'h00, 1'b0, 8'd0},
    '{rnpi_pkg::MODE_QUERY, 16'h0021, 8'hFF, 1'b0, 8'd0}
  };

  logic        clk_i;
  logic        rst_ni;
  logic        s_axis_tvalid;
  logic        s_axis_tready;
  logic [23:0] s_axis_tdata;   // [15:0] pixel_color, [23:16] entry_index
  logic        s_axis_tuser;   // [0] mode
  logic        m_axis_tvalid;
  logic        m_axis_tready;
  logic [7:0]  m_axis_tdata;   // [7:0] nearest_index

  // Known answer that travels with the offered item
  logic        offer_known;
  logic [7:0]  offer_known_idx;

  logic [15:0] palette_shadow [ENTRIES];
  logic [7:0]  nearest_due_q [$];
  int unsigned bad_results;
  int unsigned quiet_cycles;
  bit          calm;

  rgb565_nearest_palette_index_top u_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

  initial clk_i = 1'b0;
  always #10 clk_i = ~clk_i;

  // Scan the shadow palette for the lowest index at minimum squared distance
  function automatic logic [7:0] nearest_entry(input logic [15:0] px);
    int          dr;
    int          dg;
    int          db;
    int unsigned d;
    int unsigned best_d;
    logic [7:0]  best;
    best_d = rnpi_pkg::DIST_BOUND;
    best   = '0;
    for (int k = 0; k < ENTRIES; k++) begin
      dr = int'(px[15:11]) - int'(palette_shadow[k][15:11]);
      dg = int'(px[10:5]) - int'(palette_shadow[k][10:5]);
      db = int'(px[4:0]) - int'(palette_shadow[k][4:0]);
      d  = dr * dr + dg * dg + db * db;
      if (d < best_d) begin
        best_d = d;
        best   = k[7:0];
      end
    end
    return best;
  endfunction

  // Pick a color: random, a palette copy, a near miss, field extremes or black/white
  function automatic logic [15:0] pick_color();
    logic [15:0] c;
    logic [15:0] base;
    int unsigned sel;
    sel  = $urandom_range(0, 99);
    base = palette_shadow[$urandom_range(0, ENTRIES - 1)];
    if (sel < 40) begin
      c = 16'($urandom);
    end else if (sel < 60) begin
      c = base;
    end else if (sel < 75) begin
      c = base ^ (16'h0001 << $urandom_range(0, 15));
    end else if (sel < 90) begin
      c[15:11] = ($urandom_range(0, 2) == 0) ? 5'h00 :
                 ($urandom_range(0, 1) == 0) ? 5'h1F : 5'($urandom);
      c[10:5]  = ($urandom_range(0, 2) == 0) ? 6'h00 :
                 ($urandom_range(0, 1) == 0) ? 6'h3F : 6'($urandom);
      c[4:0]   = ($urandom_range(0, 2) == 0) ? 5'h00 :
                 ($urandom_range(0, 1) == 0) ? 5'h1F : 5'($urandom);
    end else begin
      c = ($urandom_range(0, 1) != 0) ? 16'hFFFF : 16'h0000;
    end
    return c;
  endfunction

  // Offer one item and hold it until the transfer
  task automatic offer_item(input logic mode, input logic [15:0] color,
                            input logic [7:0] idx, input logic known,
                            input logic [7:0] known_idx);
    s_axis_tvalid   <= 1'b1;
    s_axis_tuser    <= mode;
    s_axis_tdata    <= {idx, color};
    offer_known     <= known;
    offer_known_idx <= known_idx;
    do @(posedge clk_i); while (!s_axis_tready);
  endtask

  // Track palette writes, queue answers for queries, check results, watch for hangs
  always @(posedge clk_i) begin
    logic [7:0] due;
    if (rst_ni) begin
      if (s_axis_tvalid && s_axis_tready) begin
        if (s_axis_tuser == rnpi_pkg::MODE_WRITE) begin
          if (int'(s_axis_tdata[23:16]) < ENTRIES) begin
            palette_shadow[s_axis_tdata[23:16]] = s_axis_tdata[15:0];
          end
        end else begin
          nearest_due_q.push_back(offer_known ? offer_known_idx
                                              : nearest_entry(s_axis_tdata[15:0]));
        end
      end
      if (m_axis_tvalid && m_axis_tready) begin
        if (nearest_due_q.size() == 0) begin
          if (bad_results < 10) begin
            $display("unexpected result: nearest_index %0d", m_axis_tdata);
          end
          bad_results++;
        end else begin
          due = nearest_due_q.pop_front();
          if (m_axis_tdata !== due) begin
            if (bad_results < 10) begin
              $display("mismatch: nearest_index expected %0d got %0d", due, m_axis_tdata);
            end
            bad_results++;
          end
        end
      end
      // Count cycles with no transfer on either side
      if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
        quiet_cycles = 0;
      end else begin
        quiet_cycles++;
        if (quiet_cycles >= QUIET_LIMIT) begin
          $display("CHECK FAILED");
          $finish;
        end
      end
    end
  end

  // Receiver: random stalls, one long hold-off, none in the final stretch
  initial begin
    int unsigned taken;
    bit          held;
    taken = 0;
    held  = 0;
    m_axis_tready <= 1'b0;
    @(posedge clk_i);
    while (!rst_ni) @(posedge clk_i);
    forever begin
      if (!held && taken >= HOLD_AFTER) begin
        held = 1;
        m_axis_tready <= 1'b0;
        repeat (LONG_HOLD) @(posedge clk_i);
      end else if (!calm && $urandom_range(0, 5) == 0) begin
        m_axis_tready <= 1'b0;
        repeat ($urandom_range(1, 8)) @(posedge clk_i);
      end
      m_axis_tready <= 1'b1;
      @(posedge clk_i);
      if (m_axis_tvalid && m_axis_tready) taken++;
    end
  end

  // Sender: reset, directed table, random items, then drain and judge
  initial begin
    logic is_write;
    bad_results  = 0;
    quiet_cycles = 0;
    calm         = 0;
    rst_ni          <= 1'b0;
    s_axis_tvalid   <= 1'b0;
    s_axis_tdata    <= '0;
    s_axis_tuser    <= rnpi_pkg::MODE_QUERY;
    offer_known     <= 1'b0;
    offer_known_idx <= '0;

    // Palette after reset: ramps, mixed ramps, white at entry 0
    for (int i = 0; i < 32; i++) begin
      palette_shadow[i]       = 16'(i);
      palette_shadow[96 + i]  = 16'(i << 11);
      palette_shadow[128 + i] = 16'((16 << 5) | i);
      palette_shadow[160 + i] = 16'((16 << 5) | (i << 11));
      palette_shadow[192 + i] = 16'((48 << 5) | i);
      palette_shadow[224 + i] = 16'((48 << 5) | (i << 11));
    end
    for (int i = 0; i < 64; i++) begin
      palette_shadow[32 + i] = 16'(i << 5);
    end
    palette_shadow[0] = 16'hFFFF;

    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (DIR_ROWS[r]) begin
      offer_item(DIR_ROWS[r].mode, DIR_ROWS[r].color, DIR_ROWS[r].idx,
                 DIR_ROWS[r].known, DIR_ROWS[r].known_idx);
    end

    for (int n = 0; n < RAND_ITEMS; n++) begin
      if (n == RAND_ITEMS - CALM_ITEMS) calm = 1;
      // Pause the sender once until the chain has drained
      if (n == DRAIN_AT) begin
        s_axis_tvalid <= 1'b0;
        do @(posedge clk_i); while (nearest_due_q.size() != 0);
      end
      is_write = ($urandom_range(0, 4) == 0);
      offer_item(is_write ? rnpi_pkg::MODE_WRITE : rnpi_pkg::MODE_QUERY, pick_color(),
                 8'($urandom), 1'b0, 8'd0);
      if (!calm && $urandom_range(0, 5) == 0) begin
        s_axis_tvalid <= 1'b0;
        repeat ($urandom_range(1, 8)) @(posedge clk_i);
      end
    end
    s_axis_tvalid <= 1'b0;

    // Wait for outstanding results, then watch for strays
    do @(posedge clk_i); while (nearest_due_q.size() != 0);
    repeat (ENTRIES + 16) @(posedge clk_i);
    if (bad_results == 0 && nearest_due_q.size() == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
